>>> design/nlr_pkg.sv
// Shared types and character codes for the numeric literal recognizer.
package nlr_pkg;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_INT     = 3'd1,
    PH_FRAC    = 3'd2,
    PH_EXPSIGN = 3'd3,
    PH_EXPDIG  = 3'd4,
    PH_BAD     = 3'd5
  } phase_t;

  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_POINT = 16'h002E;
  localparam logic [15:0] CH_EXP_U = 16'h0045;
  localparam logic [15:0] CH_EXP_L = 16'h0065;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;

  localparam int          CLASS_W   = 9;
  localparam logic [8:0]  CLASS_MAX = 9'd511;

endpackage

>>> design/numeric_literal_recognizer.sv
// Top level: character-serial numeric literal recognizer.
//
//  channel  direction  payload                          handshake
//  in_      input      char_code[15:0], last_char       in_valid / in_stall
//  out_     output     number_class[8:0]                out_valid / out_stall
//
// One character per cycle while in_stall is low; the phase and counter update is one pass of logic
// from the input ports into the state registers.
// The class of a word shows on out_ in the cycle after its last character is accepted.
// A single output register holds the result; input stalls only while that
// register is full and out_stall is high.
// rst_n is synchronous; after reset the block waits at the start of a word.
module numeric_literal_recognizer
  import nlr_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_char_code,
  input  logic                in_last_char,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CLASS_W-1:0]  out_number_class
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int RW = (CW + 1 > 10) ? CW + 1 : 10;
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

  phase_t           phase_r, phase_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic [CW-1:0]    right_r, right_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0] out_class_r, out_class_nxt;

  logic             in_xfer, out_xfer;
  logic             is_digit, is_exp, have_mant, ok;
  logic             inc_left, inc_right;
  logic [RW-1:0]    class_sum;
  logic [CLASS_W-1:0] word_class;

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  assign is_digit  = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_exp    = (in_char_code == CH_EXP_U) || (in_char_code == CH_EXP_L);
  assign have_mant = (left_r != '0) || (right_r != '0);

  // Phase transition
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_START: begin
        if (in_char_code == CH_MINUS || is_digit) phase_nxt = PH_INT;
        else if (in_char_code == CH_POINT)        phase_nxt = PH_FRAC;
        else                                      phase_nxt = PH_BAD;
      end
      PH_INT: begin
        if (is_digit)                       phase_nxt = PH_INT;
        else if (in_char_code == CH_POINT)  phase_nxt = PH_FRAC;
        else if (is_exp && have_mant)       phase_nxt = PH_EXPSIGN;
        else                                phase_nxt = PH_BAD;
      end
      PH_FRAC: begin
        if (is_digit)                  phase_nxt = PH_FRAC;
        else if (is_exp && have_mant)  phase_nxt = PH_EXPSIGN;
        else                           phase_nxt = PH_BAD;
      end
      PH_EXPSIGN: begin
        if (in_char_code == CH_PLUS || in_char_code == CH_MINUS || is_digit)
          phase_nxt = PH_EXPDIG;
        else
          phase_nxt = PH_BAD;
      end
      PH_EXPDIG: begin
        if (is_digit) phase_nxt = PH_EXPDIG;
        else          phase_nxt = PH_BAD;
      end
      default: phase_nxt = PH_BAD;
    endcase
  end

  // Counter updates, all saturating at MAX_LEN
  always_comb begin
    inc_left  = 1'b0;
    inc_right = 1'b0;
    unique case (phase_r)
      PH_START:   inc_left  = is_digit;
      PH_INT:     inc_left  = is_digit;
      PH_FRAC:    inc_right = is_digit;
      PH_EXPSIGN: inc_right = is_digit;
      PH_EXPDIG:  inc_right = is_digit;
      default: begin
        inc_left  = 1'b0;
        inc_right = 1'b0;
      end
    endcase
    len_nxt   = (len_r < LEN_MAX) ? len_r + CW'(1) : LEN_MAX;
    left_nxt  = (inc_left && left_r < LEN_MAX) ? left_r + CW'(1) : left_r;
    right_nxt = (inc_right && right_r < LEN_MAX) ? right_r + CW'(1) : right_r;
  end

  // Word class from the updated state
  assign ok = (phase_nxt != PH_BAD) && (len_nxt < LEN_MAX) &&
              ((left_nxt != '0) || (right_nxt != '0));
  assign class_sum  = RW'(right_nxt) + RW'(1);
  assign word_class = !ok ? '0 :
                      (class_sum > RW'(CLASS_MAX)) ? CLASS_MAX : class_sum[CLASS_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_class_nxt = out_class_r;
    if (out_xfer) out_valid_nxt = 1'b0;
    if (in_xfer && in_last_char) begin
      out_valid_nxt = 1'b1;
      out_class_nxt = word_class;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      left_r      <= '0;
      right_r     <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        if (in_last_char) begin
          phase_r <= PH_START;
          left_r  <= '0;
          right_r <= '0;
          len_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          left_r  <= left_nxt;
          right_r <= right_nxt;
          len_r   <= len_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_number_class = out_class_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= LEN_MAX) && (left_r <= LEN_MAX) && (right_r <= LEN_MAX))
    else $error("counter above saturation limit");

  a_digits_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= len_r)
    else $error("more integer digits than characters");

  a_word_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_char |=> (phase_r == PH_START) && (len_r == '0) && out_valid_r)
    else $error("word end did not restart and post a result");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_nonzero_class: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_char && (phase_nxt == PH_BAD) |=> out_class_r == '0)
    else $error("malformed word gave nonzero class");

endmodule

>>> tb/numeric_literal_recognizer_test.sv
// Self-checking testbench for the character-serial numeric literal recognizer.

class literal_checker;
  int unsigned     word_max;
  nlr_pkg::phase_t ph;
  logic [8:0]      left_cnt;
  logic [8:0]      right_cnt;
  logic [8:0]      char_cnt;
  logic [8:0]      expected_classes[$];
  int              errors;

  function new(int unsigned max_len);
    word_max = max_len;
    errors = 0;
    restart();
  endfunction

  function void restart();
    ph = nlr_pkg::PH_START;
    left_cnt = '0;
    right_cnt = '0;
    char_cnt = '0;
  endfunction

  function logic [8:0] bump(logic [8:0] v);
    return (v < word_max) ? v + 9'd1 : 9'(word_max);
  endfunction

  // Called for every accepted input transfer; queues a class on the last character.
  function void take_char(logic [15:0] c, logic last);
    bit digit;
    bit mark;
    bit have_mant;
    int cls;
    digit = (c >= nlr_pkg::CH_ZERO) && (c <= nlr_pkg::CH_NINE);
    mark = (c == nlr_pkg::CH_EXP_U) || (c == nlr_pkg::CH_EXP_L);
    have_mant = (left_cnt != 0) || (right_cnt != 0);
    char_cnt = bump(char_cnt);
    case (ph)
      nlr_pkg::PH_START: begin
        if (c == nlr_pkg::CH_MINUS) ph = nlr_pkg::PH_INT;
        else if (digit) begin
          left_cnt = bump(left_cnt);
          ph = nlr_pkg::PH_INT;
        end else if (c == nlr_pkg::CH_POINT) ph = nlr_pkg::PH_FRAC;
        else ph = nlr_pkg::PH_BAD;
      end
      nlr_pkg::PH_INT: begin
        if (digit) left_cnt = bump(left_cnt);
        else if (c == nlr_pkg::CH_POINT) ph = nlr_pkg::PH_FRAC;
        else if (mark && have_mant) ph = nlr_pkg::PH_EXPSIGN;
        else ph = nlr_pkg::PH_BAD;
      end
      nlr_pkg::PH_FRAC: begin
        if (digit) right_cnt = bump(right_cnt);
        else if (mark && have_mant) ph = nlr_pkg::PH_EXPSIGN;
        else ph = nlr_pkg::PH_BAD;
      end
      nlr_pkg::PH_EXPSIGN: begin
        if (c == nlr_pkg::CH_PLUS || c == nlr_pkg::CH_MINUS) ph = nlr_pkg::PH_EXPDIG;
        else if (digit) begin
          right_cnt = bump(right_cnt);
          ph = nlr_pkg::PH_EXPDIG;
        end else ph = nlr_pkg::PH_BAD;
      end
      nlr_pkg::PH_EXPDIG: begin
        if (digit) right_cnt = bump(right_cnt);
        else ph = nlr_pkg::PH_BAD;
      end
      default: ph = nlr_pkg::PH_BAD;
    endcase
    if (!last) return;
    cls = 0;
    if (ph != nlr_pkg::PH_BAD && char_cnt < word_max && (left_cnt != 0 || right_cnt != 0)) begin
      cls = right_cnt + 1;
      if (cls > nlr_pkg::CLASS_MAX) cls = nlr_pkg::CLASS_MAX;
    end
    expected_classes.push_back(9'(cls));
    restart();
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_class(logic [8:0] got);
    logic [8:0] want;
    if (expected_classes.size() == 0) begin
      report($sformatf("class %0d with no word pending", got));
      return;
    end
    want = expected_classes.pop_front();
    if (got !== want) report($sformatf("number_class %0d, expected %0d", got, want));
  endtask
endclass

module numeric_literal_recognizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nlr_pkg::*;

  localparam int WORD_MAX = 256;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [15:0]         in_char_code = '0;
  logic                in_last_char = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [CLASS_W-1:0]  out_number_class;

  literal_checker sb;
  bit             quiet = 1'b0;
  int             stall_left = 0;
  logic [15:0]    word_chars[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  numeric_literal_recognizer #(.MAX_LEN(WORD_MAX)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_number_class (out_number_class)
  );

  // mostly short idles, now and then a long one; none while quiet
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // boundary codes around the grammar, or anything at all
  function automatic logic [15:0] noise_char();
    case ($urandom_range(0, 11))
      0: return CH_MINUS;
      1: return CH_PLUS;
      2: return CH_POINT;
      3: return CH_EXP_U;
      4: return CH_EXP_L;
      5: return CH_ZERO - 16'd1;
      6: return CH_NINE + 16'd1;
      7: return CH_ZERO + 16'($urandom_range(0, 9));
      8: return 16'h0000;
      9: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_class(out_number_class);
  end

  // entered and left at a falling edge
  task send_char(logic [15:0] c, logic last, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
    sb.take_char(c, last);
    @(negedge clk);
  endtask

  task send_word();
    foreach (word_chars[i]) send_char(word_chars[i], i == word_chars.size() - 1, idle_len());
  endtask

  task send_text(string s);
    word_chars.delete();
    for (int i = 0; i < s.len(); i++) word_chars.push_back({8'h00, s[i]});
    send_word();
  endtask

  task add_digits(int n);
    repeat (n) word_chars.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
  endtask

  initial begin
    int n;
    int kind;
    int sent;
    int guard;
    sb = new(WORD_MAX);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_text("0");
    send_text("-");
    send_text(".");
    send_text(".5");
    send_text("-1.5e+3");
    send_text("9E-");
    send_text("1e");
    send_text(".e1");
    send_text("5-");
    word_chars = '{16'hFFFF};
    send_word();
    word_chars = '{16'h0000};
    send_word();

    // one short of the length limit, at it, and well past it (counters saturate)
    word_chars = '{CH_ZERO + 16'd1, CH_POINT};
    add_digits(WORD_MAX - 3);
    send_word();
    word_chars = '{CH_ZERO + 16'd7};
    add_digits(WORD_MAX - 1);
    send_word();
    word_chars = '{CH_MINUS, CH_ZERO + 16'd1, CH_POINT};
    add_digits(150);
    word_chars.push_back(CH_EXP_L);
    word_chars.push_back(CH_PLUS);
    add_digits(145);
    send_word();

    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 14) == 0) quiet = !quiet;
      kind = $urandom_range(0, 9);
      word_chars.delete();
      if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) word_chars.push_back(CH_MINUS);
        add_digits($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 1) begin
          word_chars.push_back(CH_POINT);
          add_digits($urandom_range(0, 4));
        end
        if ($urandom_range(0, 2) == 0) begin
          word_chars.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
          n = $urandom_range(0, 2);
          if (n == 1) word_chars.push_back(CH_PLUS);
          else if (n == 2) word_chars.push_back(CH_MINUS);
          add_digits($urandom_range(0, 3));
        end
        if (word_chars.size() == 0) add_digits(1);
        // broken: one character replaced by a noise character (which may match it)
        if (kind >= 5) word_chars[$urandom_range(0, word_chars.size() - 1)] = noise_char();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) word_chars.push_back(noise_char());
      end
      sent += word_chars.size();
      send_word();
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.expected_classes.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.expected_classes.size() != 0)
      sb.report($sformatf("%0d words never classified", sb.expected_classes.size()));
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
